// File: src/jtkf_pkg.sv
// shared constants and helpers for the json top-level key finder
package jtkf_pkg;

    localparam int POS_W            = 12;
    localparam int MAX_BUFFER_BYTES = 4095;
    localparam int DEPTH_W          = 8;
    localparam int LEN_W            = 3;
    localparam int MODE_W           = 3;
    localparam int OUT_TDATA_W      = 16;

    localparam logic [MODE_W-1:0] MODE_OUTSIDE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STRING    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESCAPE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AFTER_KEY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE      = 3'd4;

    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;

    localparam logic [LEN_W-1:0] KEY_LEN = 3'd4;
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd5;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -8'sd128;
    localparam logic signed [DEPTH_W-1:0] DEPTH_KEY = 8'sd1;

    function automatic logic [7:0] key_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h6d;
            2'd1:    ch = 8'h61;
            2'd2:    ch = 8'h69;
            default: ch = 8'h6e;
        endcase
        return ch;
    endfunction

endpackage

// File: src/json_top_level_key_finder.sv
// json top-level key finder: locates the first top-level "main" key in a byte stream
//
// usage
//   s_axis carries one byte of json text per item; tlast marks the final byte
//   of a buffer. m_axis gives one result item per buffer, on the byte with
//   tlast: a found flag and the offset of the key's opening quote.
//   bytes at offset 4095 or later are ignored, but tlast on them still ends
//   the buffer.
// timing
//   one byte per cycle sustained unless a byte with tlast waits on a full
//   result register; the byte is held in an input register and the scan
//   state update is one short step into the state and result registers.
//   a result is registered as its last byte leaves the input register.
// reset and stall
//   reset empties both registers and returns the scanner to the start of a
//   buffer. while a result waits on m_axis, bytes that do not end a buffer
//   keep flowing; a byte with tlast waits in the input register until the
//   result register frees up.
module json_top_level_key_finder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // text_byte
    input  logic                           s_axis_tlast,  // end_of_buffer
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [jtkf_pkg::OUT_TDATA_W-1:0] m_axis_tdata // key_found, key_offset, zero pad
);
    import jtkf_pkg::*;

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    logic                       advance;

    logic [MODE_W-1:0]          mode_reg, mode_next;
    logic signed [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [POS_W-1:0]           start_reg, start_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       match_reg, match_next;
    logic                       found_reg, found_next;
    logic [POS_W-1:0]           found_pos_reg, found_pos_next;

    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [POS_W-1:0]           out_pos_reg;

    logic [7:0]                 ch;
    logic                       outside_step;

    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - POS_W - 1){1'b0}}, out_pos_reg, out_found_reg};
    assign ch            = in_byte_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        depth_next     = depth_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        match_next     = match_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        outside_step   = 1'b0;

        if (pos_reg < POS_W'(MAX_BUFFER_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (mode_reg)
                MODE_OUTSIDE:
                begin
                    outside_step = 1'b1;
                end
                MODE_STRING, MODE_ESCAPE:
                begin
                    if (mode_reg == MODE_STRING && ch == CH_QUOTE)
                    begin
                        if (depth_reg == DEPTH_KEY && len_reg == KEY_LEN && match_reg)
                            mode_next = MODE_AFTER_KEY;
                        else
                            mode_next = MODE_OUTSIDE;
                    end
                    else
                    begin
                        if (mode_reg == MODE_ESCAPE)
                            mode_next = MODE_STRING;
                        else if (ch == CH_BSLASH)
                            mode_next = MODE_ESCAPE;
                        if (len_reg >= KEY_LEN || ch != key_char(len_reg[1:0]))
                            match_next = 1'b0;
                        if (len_reg < LEN_MAX)
                            len_next = len_reg + LEN_W'(1);
                    end
                end
                MODE_AFTER_KEY:
                begin
                    if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)
                        mode_next = MODE_AFTER_KEY;
                    else if (ch == CH_COLON)
                    begin
                        found_next     = 1'b1;
                        found_pos_next = start_reg;
                        mode_next      = MODE_DONE;
                    end
                    else
                    begin
                        mode_next    = MODE_OUTSIDE;
                        outside_step = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase

            if (outside_step)
            begin
                if (ch == CH_LBRACE || ch == CH_LBRACK)
                begin
                    if (depth_reg < DEPTH_MAX)
                        depth_next = depth_reg + 8'sd1;
                end
                else if (ch == CH_RBRACE || ch == CH_RBRACK)
                begin
                    if (depth_reg > DEPTH_MIN)
                        depth_next = depth_reg - 8'sd1;
                end
                else if (ch == CH_QUOTE)
                begin
                    mode_next  = MODE_STRING;
                    start_next = pos_reg;
                    len_next   = '0;
                    match_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_OUTSIDE;
            depth_reg     <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            len_reg       <= '0;
            match_reg     <= 1'b1;
            found_reg     <= 1'b0;
            found_pos_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                if (in_last_reg)
                begin
                    out_valid_reg <= 1'b1;
                    mode_reg      <= MODE_OUTSIDE;
                    depth_reg     <= '0;
                    pos_reg       <= '0;
                    start_reg     <= '0;
                    len_reg       <= '0;
                    match_reg     <= 1'b1;
                    found_reg     <= 1'b0;
                    found_pos_reg <= '0;
                end
                else
                begin
                    mode_reg      <= mode_next;
                    depth_reg     <= depth_next;
                    pos_reg       <= pos_next;
                    start_reg     <= start_next;
                    len_reg       <= len_next;
                    match_reg     <= match_next;
                    found_reg     <= found_next;
                    found_pos_reg <= found_pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_found_reg <= found_next;
            out_pos_reg   <= found_next ? found_pos_next : '0;
        end
    end

endmodule

// File: dv/tb_top.sv
// testbench for the json top-level key finder: byte stream scans checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jtkf_pkg::*;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] offset;
    } key_result_t;

    localparam logic [7:0] KEY_BYTES [4] = '{"m", "a", "i", "n"};
    localparam int RANDOM_BYTES = 1550;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;  // text_byte
    logic                   s_axis_tlast = 1'b0;   // end_of_buffer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // key_found, key_offset, zero pad

    json_top_level_key_finder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // scanner copy
    logic [MODE_W-1:0]         scan_state = MODE_OUTSIDE;
    logic signed [DEPTH_W-1:0] depth = '0;
    logic [POS_W-1:0]          pos = '0;
    logic [POS_W-1:0]          quote_pos = '0;
    logic [LEN_W-1:0]          key_len = '0;
    logic                      key_ok = 1'b1;
    logic                      hit = 1'b0;
    logic [POS_W-1:0]          hit_pos = '0;

    key_result_t key_results_q[$];
    logic [7:0]  text_q[$];

    int err_count = 0;
    int bytes_sent = 0;
    int buffers_sent = 0;
    int keys_found = 0;
    int results_seen = 0;
    int burst_left = 0;

    function automatic void clear_scan();
        scan_state = MODE_OUTSIDE;
        depth      = '0;
        pos        = '0;
        quote_pos  = '0;
        key_len    = '0;
        key_ok     = 1'b1;
        hit        = 1'b0;
        hit_pos    = '0;
    endfunction

    function automatic void track_structure(input logic [7:0] b, input logic [POS_W-1:0] p);
        if (b == CH_LBRACE || b == CH_LBRACK)
        begin
            if (depth != DEPTH_MAX)
                depth = depth + 8'sd1;
        end
        else if (b == CH_RBRACE || b == CH_RBRACK)
        begin
            if (depth != DEPTH_MIN)
                depth = depth - 8'sd1;
        end
        else if (b == CH_QUOTE)
        begin
            scan_state = MODE_STRING;
            quote_pos  = p;
            key_len    = '0;
            key_ok     = 1'b1;
        end
    endfunction

    function automatic void match_key_byte(input logic [7:0] b);
        if (key_len >= KEY_LEN || b != KEY_BYTES[key_len[1:0]])
            key_ok = 1'b0;
        if (key_len < LEN_MAX)
            key_len = key_len + 1'b1;
    endfunction

    function automatic void scan_text_byte(input logic [7:0] b, input logic last);
        key_result_t r;
        if (int'(pos) < MAX_BUFFER_BYTES)
        begin
            case (scan_state)
                MODE_OUTSIDE:
                    track_structure(b, pos);
                MODE_STRING:
                    if (b == CH_QUOTE)
                        scan_state = (depth == DEPTH_KEY && key_len == KEY_LEN && key_ok)
                                     ? MODE_AFTER_KEY : MODE_OUTSIDE;
                    else
                    begin
                        if (b == CH_BSLASH)
                            scan_state = MODE_ESCAPE;
                        match_key_byte(b);
                    end
                MODE_ESCAPE:
                begin
                    match_key_byte(b);
                    scan_state = MODE_STRING;
                end
                MODE_AFTER_KEY:
                    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
                        scan_state = MODE_AFTER_KEY;
                    else if (b == CH_COLON)
                    begin
                        hit        = 1'b1;
                        hit_pos    = quote_pos;
                        scan_state = MODE_DONE;
                    end
                    else
                    begin
                        scan_state = MODE_OUTSIDE;
                        track_structure(b, pos);
                    end
                default:
                    scan_state = scan_state;
            endcase
            pos = pos + 1'b1;
        end
        if (last)
        begin
            r.found  = hit;
            r.offset = hit ? hit_pos : '0;
            key_results_q.push_back(r);
            if (hit)
                keys_found++;
            buffers_sent++;
            clear_scan();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scan_text_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic void append_text(input string s);
        foreach (s[i])
            text_q.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        append_text(s);
        send_buffer();
    endtask

    function automatic void append_space();
        int n;
        n = $urandom_range(0, 3);
        repeat (n)
            case ($urandom_range(0, 4))
                0:       text_q.push_back(CH_TAB);
                1:       text_q.push_back(CH_CR);
                2:       text_q.push_back(CH_LF);
                default: text_q.push_back(CH_SPACE);
            endcase
    endfunction

    function automatic void append_key();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: append_text("\"main\"");
            4:          append_text("\"mai\"");
            5:          append_text("\"mainx\"");
            6:          append_text("\"m\\ain\"");
            7:          append_text("\"ma\\\"n\"");
            8:          append_text("\"Main\"");
            default:
            begin
                n = $urandom_range(0, 6);
                text_q.push_back(CH_QUOTE);
                repeat (n)
                    text_q.push_back(8'($urandom_range(0, 255)));
                text_q.push_back(CH_QUOTE);
            end
        endcase
    endfunction

    function automatic void append_value(input int lvl);
        int n;
        case ($urandom_range(0, 5))
            0:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
            end
            1:  append_key();
            2:  append_text("true");
            3, 4:
                if (lvl < 2)
                begin
                    text_q.push_back(CH_LBRACE);
                    append_space();
                    append_key();
                    append_space();
                    text_q.push_back(CH_COLON);
                    append_value(lvl + 1);
                    text_q.push_back(CH_RBRACE);
                end
                else
                    text_q.push_back(8'($urandom_range(0, 255)));
            default:
                if (lvl < 2)
                begin
                    text_q.push_back(CH_LBRACK);
                    append_value(lvl + 1);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        text_q.push_back(8'h2c);
                        append_value(lvl + 1);
                    end
                    text_q.push_back(CH_RBRACK);
                end
                else
                    append_text("null");
        endcase
    endfunction

    task automatic test_plain_keys();
        send_text("{\"main\":1}");
        send_text("{\"main\" \t\r\n:0}");
        send_text("[\"main\":");
        send_text("{\"x\":{\"main\":1},\"main\":2}");
        send_text("{\"mai\":1,\"mainx\":2,\"Main\":3}");
    endtask

    task automatic test_no_colon();
        send_text("{\"main\" x \"main\" :3}");
        send_text("{\"main\"\"main\":1}");
        send_text("{\"main\"{\"main\":1}");
        send_text("{\"main\"");
        send_text("{\"main\"  ");
    endtask

    task automatic test_escapes();
        send_text("{\"ma\\\"n\":1}");
        send_text("{\"m\\ain\":1}");
        send_text("{\"main\\\":1}");
        send_text("{\"\\\\\":1,\"main\":2}");
    endtask

    task automatic test_edge_bytes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_text("{}");
        send_text("{\"main\":\"main\",\"main\":[[[}");
    endtask

    task automatic test_depth_limits();
        append_text("}}{\"main\":1}");
        send_buffer();
        // negative saturation: 130 closers then 129 openers land on depth one
        repeat (130) text_q.push_back(CH_RBRACE);
        repeat (129) text_q.push_back(CH_LBRACK);
        append_text("\"main\":0");
        send_buffer();
        repeat (130) text_q.push_back(CH_LBRACE);
        repeat (126) text_q.push_back(CH_RBRACK);
        append_text("\"main\":0");
        send_buffer();
    endtask

    task automatic test_long_buffer();
        // colon falls on the first ignored offset, tlast lands past the limit
        text_q.push_back(CH_LBRACE);
        while (text_q.size() < 4089)
            text_q.push_back(CH_SPACE);
        append_text("\"main\":1}");
        send_buffer();
    endtask

    task automatic test_random_buffers();
        int start;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    text_q.push_back(CH_LBRACK);
                append_space();
                text_q.push_back(CH_LBRACE);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    append_space();
                    append_key();
                    append_space();
                    if ($urandom_range(0, 7) != 0)
                        text_q.push_back(CH_COLON);
                    append_space();
                    append_value(0);
                    if (i < n - 1)
                        text_q.push_back(8'h2c);
                end
                if ($urandom_range(0, 9) != 0)
                    text_q.push_back(CH_RBRACE);
            end
            send_buffer();
        end
    endtask

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    int rx_cycle = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rx_cycle % 5 == 0);
            default: m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        key_result_t want;
        key_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found  = m_axis_tdata[0];
            got.offset = m_axis_tdata[POS_W:1];
            results_seen++;
            if (key_results_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result found=%0b offset=%0d",
                         $time, got.found, got.offset);
            end
            else
            begin
                want = key_results_q.pop_front();
                if (got.found !== want.found)
                begin
                    err_count++;
                    $display("%0t: key_found expected %0b actual %0b",
                             $time, want.found, got.found);
                end
                if (got.offset !== want.offset)
                begin
                    err_count++;
                    $display("%0t: key_offset expected %0d actual %0d",
                             $time, want.offset, got.offset);
                end
            end
            if (m_axis_tdata[OUT_TDATA_W-1:POS_W+1] !== '0)
            begin
                err_count++;
                $display("%0t: pad bits expected 0 actual %0h",
                         $time, m_axis_tdata[OUT_TDATA_W-1:POS_W+1]);
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_keys();
        test_no_colon();
        test_escapes();
        test_edge_bytes();
        test_depth_limits();
        test_long_buffer();
        test_random_buffers();
        s_axis_tvalid <= 1'b0;
        while (key_results_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("scanned %0d bytes in %0d buffers, %0d results checked, key found in %0d",
                 bytes_sent, buffers_sent, results_seen, keys_found);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", key_results_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
